// ===== hw/rtl/pirwt_pkg.sv =====
// package for the per-id rate watchdog table: commands, register indexes,
// entry and result records, state machine type and sizing constants
// no dependencies
package pirwt_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      CMD_REGISTER = 2'd0,
      CMD_MESSAGE  = 2'd1,
      CMD_FORK     = 2'd2,
      CMD_SWEEP    = 2'd3
   } cmd_type;

   typedef logic [2:0] csr_idx_type;

   localparam csr_idx_type CSR_ENFORCE_ENABLE = 3'd0;
   localparam csr_idx_type CSR_MSG_LIMIT      = 3'd1;
   localparam csr_idx_type CSR_FORK_LIMIT     = 3'd2;
   localparam csr_idx_type CSR_WINDOW_LEN_MS  = 3'd3;
   localparam csr_idx_type CSR_DECAY_AGE_MS   = 3'd4;
   localparam csr_idx_type CSR_STRIKE_LIMIT   = 3'd5;

   localparam int CSR_DATA_W = 16;

   localparam logic        RST_ENFORCE_ENABLE = 1'b1;
   localparam logic [15:0] RST_MSG_LIMIT      = 16'd100;
   localparam logic [15:0] RST_FORK_LIMIT     = 16'd64;
   localparam logic [15:0] RST_WINDOW_LEN_MS  = 16'd1000;
   localparam logic [15:0] RST_DECAY_AGE_MS   = 16'd5000;
   localparam logic [7:0]  RST_STRIKE_LIMIT   = 8'd3;

   localparam logic [15:0] CNT16_MAX = 16'hFFFF;
   localparam logic [7:0]  CNT8_MAX  = 8'hFF;

   typedef struct packed {
      logic [31:0] id;
      logic [15:0] msg_count;
      logic [63:0] window_start;
      logic [7:0]  strike_count;
      logic [15:0] fork_count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic        accepted;
      logic        found;
      logic        flood;
      logic        evict;
      logic        registered;
      logic [31:0] target_id;
   } res_type;

   localparam res_type RES_IDLE = '{accepted: 1'b1, found: 1'b0, flood: 1'b0,
                                    evict: 1'b0, registered: 1'b0,
                                    target_id: 32'd0};

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_CALC,
      S_DONE
   } state_type;

endpackage

// ===== hw/rtl/pirwt_req_if.sv =====
// request channel of the rate watchdog table: valid/ready and event payload
// no dependencies
interface pirwt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] proc_id;
   logic [63:0] now_ms;

   modport source (output valid, command, proc_id, now_ms, input ready);
   modport sink   (input valid, command, proc_id, now_ms, output ready);
endinterface

// ===== hw/rtl/pirwt_rsp_if.sv =====
// response channel of the rate watchdog table: valid/ready and verdict payload
// no dependencies
interface pirwt_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        found;
   logic        flood;
   logic        evict;
   logic        registered;
   logic [31:0] target_id;

   modport source (output valid, accepted, found, flood, evict, registered, target_id,
                   input ready);
   modport sink   (input valid, accepted, found, flood, evict, registered, target_id,
                   output ready);
endinterface

// ===== hw/rtl/per_id_rate_watchdog_table_top.sv =====
// Rate watchdog table for up to ENTRIES process ids (default 16). One item
// is handled at a time. A register command writes its entry, if it has room,
// when it is accepted and goes straight to the done state. A message, fork or
// sweep item scans the entry memory one entry per cycle through its single
// read port (a lookup stops at its first match, a sweep always visits every
// used entry); a message with enforcement off, or any scan of an empty
// table, goes straight to the done state. Entries are only ever appended,
// so the fill count marks which entries are live and no clearing pass runs
// after reset. The response sits in an output register, and a new item is
// taken as soon as the previous one has been handed to it.
// depends on pirwt_pkg, pirwt_req_if, pirwt_rsp_if and pirwt_ram
module per_id_rate_watchdog_table_top (
   input  logic                      clock,
   input  logic                      reset,
   pirwt_req_if.sink                 req,
   pirwt_rsp_if.source               rsp,
   input  logic                      csr_we,
   input  pirwt_pkg::csr_idx_type    csr_index,
   input  logic [pirwt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pirwt_pkg::*;

   // configuration registers
   logic        enforce_ff;
   logic [15:0] msg_limit_ff;
   logic [15:0] fork_limit_ff;
   logic [15:0] window_len_ff;
   logic [15:0] decay_age_ff;
   logic [7:0]  strike_limit_ff;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [31:0] id_ff, id_in;
   logic [63:0] now_ff, now_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] nxt_ff, nxt_in;
   logic        pend_ff, pend_in;
   logic [IDX_W-1:0] didx_ff, didx_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   entry_type   ent_ff, ent_in;
   logic        aged_ff, aged_in;
   res_type     res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   res_type     rsp_res_ff, rsp_res_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   entry_type        ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type        rd;

   logic [63:0] age;
   logic [15:0] age_lim;
   logic        aged;
   logic        last;
   logic [15:0] msg_base;
   logic [15:0] msg_new;
   logic [7:0]  strike_new;
   logic [15:0] fork_new;
   logic        flood_c;
   logic        evict_c;

   pirwt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (nxt_ff[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enforce_ff      <= RST_ENFORCE_ENABLE;
         msg_limit_ff    <= RST_MSG_LIMIT;
         fork_limit_ff   <= RST_FORK_LIMIT;
         window_len_ff   <= RST_WINDOW_LEN_MS;
         decay_age_ff    <= RST_DECAY_AGE_MS;
         strike_limit_ff <= RST_STRIKE_LIMIT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENFORCE_ENABLE: enforce_ff      <= csr_wdata[0];
            CSR_MSG_LIMIT:      msg_limit_ff    <= csr_wdata[15:0];
            CSR_FORK_LIMIT:     fork_limit_ff   <= csr_wdata[15:0];
            CSR_WINDOW_LEN_MS:  window_len_ff   <= csr_wdata[15:0];
            CSR_DECAY_AGE_MS:   decay_age_ff    <= csr_wdata[15:0];
            CSR_STRIKE_LIMIT:   strike_limit_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      id_ff      <= id_in;
      now_ff     <= now_in;
      nxt_ff     <= nxt_in;
      didx_ff    <= didx_in;
      hit_idx_ff <= hit_idx_in;
      ent_ff     <= ent_in;
      aged_ff    <= aged_in;
      res_ff     <= res_in;
      rsp_res_ff <= rsp_res_in;
   end

   // age test on the entry coming out of the memory
   assign rd      = entry_type'(ram_rdata);
   assign age     = now_ff - rd.window_start;
   assign age_lim = (cmd_ff == CMD_SWEEP) ? decay_age_ff : window_len_ff;
   assign aged    = (age >= 64'(age_lim));
   assign last    = ((CNT_W'(didx_ff) + CNT_W'(1)) == used_ff);

   // update of a matched entry, working from the captured copy
   assign msg_base   = aged_ff ? 16'd0 : ent_ff.msg_count;
   assign msg_new    = (msg_base != CNT16_MAX) ? msg_base + 16'd1 : msg_base;
   assign flood_c    = (msg_new > msg_limit_ff);
   assign strike_new = (flood_c && ent_ff.strike_count != CNT8_MAX)
                       ? ent_ff.strike_count + 8'd1 : ent_ff.strike_count;
   assign fork_new   = (ent_ff.fork_count != CNT16_MAX)
                       ? ent_ff.fork_count + 16'd1 : ent_ff.fork_count;
   assign evict_c    = (cmd_ff == CMD_FORK) ? (fork_new > fork_limit_ff)
                       : (flood_c && strike_new >= strike_limit_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      now_in       = now_ff;
      used_in      = used_ff;
      nxt_in       = nxt_ff;
      pend_in      = 1'b0;
      didx_in      = didx_ff;
      hit_idx_in   = hit_idx_ff;
      ent_in       = ent_ff;
      aged_in      = aged_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_res_in   = rsp_res_ff;
      ram_we       = 1'b0;
      ram_waddr    = hit_idx_ff;
      ram_wdata    = ent_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in = cmd_type'(req.command);
               id_in  = req.proc_id;
               now_in = req.now_ms;
               nxt_in = '0;
               res_in = RES_IDLE;
               unique case (cmd_type'(req.command))
                  CMD_REGISTER: begin
                     if (used_ff < CNT_W'(ENTRIES)) begin
                        ram_we    = 1'b1;
                        ram_waddr = used_ff[IDX_W-1:0];
                        ram_wdata = '{id: req.proc_id, msg_count: 16'd0,
                                      window_start: req.now_ms, strike_count: 8'd0,
                                      fork_count: 16'd1};
                        used_in   = used_ff + CNT_W'(1);
                        res_in.registered = 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  CMD_MESSAGE: begin
                     state_in = (enforce_ff && used_ff != '0) ? S_SCAN : S_DONE;
                  end
                  default: begin
                     state_in = (used_ff != '0) ? S_SCAN : S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (nxt_ff < used_ff) begin
               pend_in = 1'b1;
               didx_in = nxt_ff[IDX_W-1:0];
               nxt_in  = nxt_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (cmd_ff == CMD_SWEEP) begin
                  // write-back goes one entry behind the read, never the same entry
                  if (aged) begin
                     ram_we    = 1'b1;
                     ram_waddr = didx_ff;
                     ram_wdata = rd;
                     ram_wdata.msg_count    = 16'd0;
                     ram_wdata.window_start = now_ff;
                     ram_wdata.strike_count = (rd.strike_count != 8'd0)
                                              ? rd.strike_count - 8'd1 : 8'd0;
                  end
                  if (last) begin
                     state_in = S_DONE;
                  end
               end else if (rd.id == id_ff) begin
                  ent_in     = rd;
                  aged_in    = aged;
                  hit_idx_in = didx_ff;
                  pend_in    = 1'b0;
                  state_in   = S_CALC;
               end else if (last) begin
                  state_in = S_DONE;
               end
            end
         end
         S_CALC: begin
            ram_we    = 1'b1;
            ram_waddr = hit_idx_ff;
            ram_wdata = ent_ff;
            res_in.found    = 1'b1;
            res_in.evict    = evict_c;
            res_in.accepted = !evict_c;
            if (cmd_ff == CMD_FORK) begin
               ram_wdata.fork_count = fork_new;
               res_in.flood         = 1'b0;
               res_in.target_id     = evict_c ? id_ff : 32'd0;
            end else begin
               ram_wdata.msg_count    = msg_new;
               ram_wdata.strike_count = strike_new;
               if (aged_ff) begin
                  ram_wdata.window_start = now_ff;
               end
               res_in.flood     = flood_c;
               res_in.target_id = (flood_c || evict_c) ? id_ff : 32'd0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.accepted   = rsp_res_ff.accepted;
   assign rsp.found      = rsp_res_ff.found;
   assign rsp.flood      = rsp_res_ff.flood;
   assign rsp.evict      = rsp_res_ff.evict;
   assign rsp.registered = rsp_res_ff.registered;
   assign rsp.target_id  = rsp_res_ff.target_id;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(ENTRIES))
      else $error("fill count beyond table size");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response loaded outside the done state");

   a_evict_rejects: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_res_ff.accepted != rsp_res_ff.evict))
      else $error("accepted and evict disagree");

   a_one_write_per_calc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CALC) |=> (state_ff == S_DONE))
      else $error("update did not complete in one cycle");
`endif

endmodule

// ===== hw/rtl/pirwt_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module pirwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
